>>> sv/ctic_pkg.sv
// Package for the CPU timer and interrupt controller.
// Holds command, page and register offset codes, line bit positions and the result struct.
// No dependencies.
package ctic_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_LINE  = 2'd3;

  localparam logic [1:0] PAGE_TIMER = 2'd0;
  localparam logic [1:0] PAGE_IRQ   = 2'd1;

  localparam logic [1:0] TMR_PRELOAD = 2'd0;
  localparam logic [1:0] TMR_CONTROL = 2'd1;
  localparam logic [1:0] INT_MASK    = 2'd2;
  localparam logic [1:0] IRQ_STATUS  = 2'd3;

  localparam int PEND_IRQ2  = 0;
  localparam int PEND_IRQ1  = 1;
  localparam int PEND_TIMER = 2;

  localparam logic LINE_IRQ1 = 1'b0;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] pending_lines;
    logic [2:0] request_lines;
    logic       timer_fired;
  } result_t;

endpackage

>>> sv/ctic_core.sv
// Timer and interrupt state of the controller with the per-transaction update logic.
// Produces the result of the transaction being accepted; depends on ctic_pkg.
// The state registers are updated at the same edge that accepts the transaction.
module ctic_core #(
  parameter int TIMER_PRESCALE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        command,
  input  logic [18:0]       elapsed_cycles,
  input  logic [1:0]        io_page,
  input  logic [1:0]        reg_offset,
  input  logic [7:0]        write_data,
  input  logic              line_select,
  input  logic              line_level,
  output ctic_pkg::result_t res
);

  localparam int CW = $clog2(128 * TIMER_PRESCALE + 1);
  localparam int XW = (CW > 19) ? CW : 19;
  localparam int PL = $clog2(TIMER_PRESCALE);
  localparam int SH = CW + PL;
  localparam longint RECIP = ((64'd1 << SH) + TIMER_PRESCALE - 1) / TIMER_PRESCALE;
  localparam logic [CW-1:0] PRESCALE_W = CW'(TIMER_PRESCALE);
  localparam logic [CW:0] RECIP_W = (CW + 1)'(RECIP);

  logic [CW-1:0] timer_count;
  logic [CW-1:0] timer_reload;
  logic          timer_running;
  logic [2:0]    line_mask;
  logic [2:0]    line_pending;
  logic [7:0]    bus_latch;

  logic [CW-1:0] timer_count_next;
  logic [CW-1:0] timer_reload_next;
  logic          timer_running_next;
  logic [2:0]    line_mask_next;
  logic [2:0]    line_pending_next;
  logic [7:0]    bus_latch_next;

  logic [CW-1:0]   preload_value;
  logic [2*CW:0]   quot_product;
  logic [6:0]      count_scaled;
  logic            expire;
  logic [7:0]      read_value;
  logic            fired;

  assign preload_value = CW'(write_data[6:0]) * PRESCALE_W + PRESCALE_W;
  assign quot_product  = (2 * CW + 1)'(timer_count) * (2 * CW + 1)'(RECIP_W);
  assign count_scaled  = quot_product[SH+6:SH];
  assign expire        = XW'(elapsed_cycles) >= XW'(timer_count);

  always_comb begin
    case (io_page)
      ctic_pkg::PAGE_TIMER: begin
        read_value = {bus_latch[7], count_scaled};
      end
      ctic_pkg::PAGE_IRQ: begin
        case (reg_offset)
          ctic_pkg::INT_MASK:   read_value = {bus_latch[7:3], line_mask};
          ctic_pkg::IRQ_STATUS: read_value = {bus_latch[7:3], line_pending};
          default:              read_value = bus_latch;
        endcase
      end
      default: begin
        read_value = bus_latch;
      end
    endcase
  end

  always_comb begin
    timer_count_next   = timer_count;
    timer_reload_next  = timer_reload;
    timer_running_next = timer_running;
    line_mask_next     = line_mask;
    line_pending_next  = line_pending;
    bus_latch_next     = bus_latch;
    fired              = 1'b0;
    case (command)
      ctic_pkg::CMD_TICK: begin
        if (timer_running) begin
          if (expire) begin
            timer_count_next = timer_reload;
            line_pending_next[ctic_pkg::PEND_TIMER] = 1'b1;
            fired = 1'b1;
          end else begin
            timer_count_next = CW'(XW'(timer_count) - XW'(elapsed_cycles));
          end
        end
      end
      ctic_pkg::CMD_WRITE: begin
        bus_latch_next = write_data;
        if (io_page == ctic_pkg::PAGE_TIMER) begin
          if (reg_offset == ctic_pkg::TMR_PRELOAD) begin
            timer_reload_next = preload_value;
            timer_count_next  = preload_value;
          end else if (reg_offset == ctic_pkg::TMR_CONTROL) begin
            if (write_data[0] && !timer_running) begin
              timer_count_next = timer_reload;
            end
            timer_running_next = write_data[0];
          end
        end else if (io_page == ctic_pkg::PAGE_IRQ) begin
          if (reg_offset == ctic_pkg::INT_MASK) begin
            line_mask_next = write_data[2:0];
          end else if (reg_offset == ctic_pkg::IRQ_STATUS) begin
            line_pending_next[ctic_pkg::PEND_TIMER] = 1'b0;
          end
        end
      end
      ctic_pkg::CMD_READ: begin
      end
      default: begin
        if (line_select == ctic_pkg::LINE_IRQ1) begin
          line_pending_next[ctic_pkg::PEND_IRQ1] = line_level;
        end else begin
          line_pending_next[ctic_pkg::PEND_IRQ2] = line_level;
        end
      end
    endcase
  end

  always_comb begin
    res.read_data     = (command == ctic_pkg::CMD_READ) ? read_value : 8'd0;
    res.pending_lines = line_pending_next;
    res.request_lines = line_pending_next & ~line_mask_next;
    res.timer_fired   = fired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count   <= '0;
      timer_reload  <= '0;
      timer_running <= 1'b0;
      line_mask     <= 3'd0;
      line_pending  <= 3'd0;
      bus_latch     <= 8'd0;
    end else if (accept) begin
      timer_count   <= timer_count_next;
      timer_reload  <= timer_reload_next;
      timer_running <= timer_running_next;
      line_mask     <= line_mask_next;
      line_pending  <= line_pending_next;
      bus_latch     <= bus_latch_next;
    end
  end

  // The count never exceeds the value it reloads from.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    timer_count <= timer_reload)
    else $error("timer count above reload value");

  // Expiry can only come from a tick while the timer runs.
  a_fire_source: assert property (@(posedge clk) disable iff (rst)
    res.timer_fired |-> (command == ctic_pkg::CMD_TICK) && timer_running)
    else $error("timer fired outside a running tick");

  // A stopped timer keeps its count across ticks.
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    accept && (command == ctic_pkg::CMD_TICK) && !timer_running |=> $stable(timer_count))
    else $error("stopped timer count changed");

  // An accepted expiry leaves the timer line pending.
  a_fire_pending: assert property (@(posedge clk) disable iff (rst)
    accept && res.timer_fired |=> line_pending[ctic_pkg::PEND_TIMER])
    else $error("timer line not pending after expiry");

endmodule

>>> sv/cpu_timer_and_irq_controller_top.sv
// Top level of the CPU timer and interrupt controller: handshakes and result buffering.
// Instantiates ctic_core; depends on ctic_pkg.
//
// One transaction (tick, bus write, bus read or line change) can be accepted in every cycle
// while the skid register is empty: the core updates its state at the accepting edge and the
// result enters the output register, or the skid register behind it when the output still holds
// a result that is not taken, so that input acceptance does not depend combinationally on
// out_stall. in_stall rises only when both the output and skid registers hold results that
// have not been taken.
module cpu_timer_and_irq_controller_top #(
  parameter int TIMER_PRESCALE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [18:0] elapsed_cycles,
  input  logic [1:0]  io_page,
  input  logic [1:0]  reg_offset,
  input  logic [7:0]  write_data,
  input  logic        line_select,
  input  logic        line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [2:0]  pending_lines,
  output logic [2:0]  request_lines,
  output logic        timer_fired
);

  logic              accept;
  logic              pop;
  logic              skid_valid;
  ctic_pkg::result_t core_res;
  ctic_pkg::result_t out_res;
  ctic_pkg::result_t skid_res;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;

  ctic_core #(
    .TIMER_PRESCALE(TIMER_PRESCALE)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (command),
    .elapsed_cycles(elapsed_cycles),
    .io_page       (io_page),
    .reg_offset    (reg_offset),
    .write_data    (write_data),
    .line_select   (line_select),
    .line_level    (line_level),
    .res           (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_res <= core_res;
      end else begin
        out_res <= core_res;
      end
    end
  end

  assign read_data     = out_res.read_data;
  assign pending_lines = out_res.pending_lines;
  assign request_lines = out_res.request_lines;
  assign timer_fired   = out_res.timer_fired;

  // The skid register only fills behind a waiting output result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result with the output empty");

  // A stalled output with a full skid register keeps both results.
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && out_valid)
    else $error("buffered result lost under stall");

  // Requested lines are always a subset of the pending lines.
  a_request_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((request_lines & ~pending_lines) == 3'd0))
    else $error("request line without pending line");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for cpu_timer_and_irq_controller_top: directed and random ticks,
// bus accesses and line changes with random idling on both sides, checked against a predictor.
// Depends on ctic_pkg and the controller RTL.
module testbench;

  localparam int TIMER_PRESCALE = 1024;
  localparam int RANDOM_ITEMS = 925;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] PAGE_OTHER = 2'd2;
  localparam logic [1:0] PAGE_SPARE = 2'd3;
  localparam logic [1:0] OFS_LATCH0 = 2'd0;
  localparam logic [1:0] OFS_LATCH1 = 2'd1;
  localparam logic LINE_IRQ2 = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [18:0] elapsed;
    logic [1:0]  page;
    logic [1:0]  offset;
    logic [7:0]  data;
    logic        sel;
    logic        level;
  } ctic_item_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [18:0] elapsed_cycles;
  logic [1:0]  io_page;
  logic [1:0]  reg_offset;
  logic [7:0]  write_data;
  logic        line_select;
  logic        line_level;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic [2:0]  pending_lines;
  logic [2:0]  request_lines;
  logic        timer_fired;

  ctic_item_t        ctic_cmd_q[$];
  ctic_pkg::result_t ctic_resp_q[$];
  ctic_item_t        cur_item;
  ctic_pkg::result_t want;

  logic [17:0] tmr_count;
  logic [17:0] tmr_reload;
  logic        tmr_running;
  logic [2:0]  line_mask;
  logic [2:0]  line_pending;
  logic [7:0]  bus_latch;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  int  in_calm = 0;
  int  out_calm = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;

  cpu_timer_and_irq_controller_top #(
    .TIMER_PRESCALE(TIMER_PRESCALE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .elapsed_cycles(elapsed_cycles),
    .io_page(io_page),
    .reg_offset(reg_offset),
    .write_data(write_data),
    .line_select(line_select),
    .line_level(line_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .pending_lines(pending_lines),
    .request_lines(request_lines),
    .timer_fired(timer_fired)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Applies one transaction to the predicted controller state and returns its response.
  function automatic ctic_pkg::result_t ctic_execute(ctic_item_t it);
    ctic_pkg::result_t r;
    r = '0;
    case (it.command)
      ctic_pkg::CMD_TICK: begin
        if (tmr_running) begin
          if (it.elapsed >= {1'b0, tmr_count}) begin
            tmr_count = tmr_reload;
            line_pending[ctic_pkg::PEND_TIMER] = 1'b1;
            r.timer_fired = 1'b1;
          end else begin
            tmr_count = tmr_count - 18'(it.elapsed);
          end
        end
      end
      ctic_pkg::CMD_WRITE: begin
        bus_latch = it.data;
        if (it.page == ctic_pkg::PAGE_TIMER) begin
          if (it.offset == ctic_pkg::TMR_PRELOAD) begin
            tmr_reload = 18'((int'(it.data[6:0]) + 1) * TIMER_PRESCALE);
            tmr_count = tmr_reload;
          end else if (it.offset == ctic_pkg::TMR_CONTROL) begin
            if (it.data[0] && !tmr_running) tmr_count = tmr_reload;
            tmr_running = it.data[0];
          end
        end else if (it.page == ctic_pkg::PAGE_IRQ) begin
          if (it.offset == ctic_pkg::INT_MASK) line_mask = it.data[2:0];
          else if (it.offset == ctic_pkg::IRQ_STATUS) line_pending[ctic_pkg::PEND_TIMER] = 1'b0;
        end
      end
      ctic_pkg::CMD_READ: begin
        r.read_data = bus_latch;
        if (it.page == ctic_pkg::PAGE_TIMER) begin
          r.read_data = {bus_latch[7], 7'(tmr_count / TIMER_PRESCALE)};
        end else if (it.page == ctic_pkg::PAGE_IRQ) begin
          if (it.offset == ctic_pkg::INT_MASK) begin
            r.read_data = {bus_latch[7:3], line_mask};
          end else if (it.offset == ctic_pkg::IRQ_STATUS) begin
            r.read_data = {bus_latch[7:3], line_pending};
          end
        end
      end
      default: begin
        if (it.sel == ctic_pkg::LINE_IRQ1) line_pending[ctic_pkg::PEND_IRQ1] = it.level;
        else line_pending[ctic_pkg::PEND_IRQ2] = it.level;
      end
    endcase
    r.pending_lines = line_pending;
    r.request_lines = line_pending & ~line_mask;
    return r;
  endfunction

  function automatic ctic_item_t mk_item(logic [1:0] c, logic [18:0] e, logic [1:0] p,
                                         logic [1:0] o, logic [7:0] d, logic s, logic l);
    ctic_item_t it;
    it = '{command: c, elapsed: e, page: p, offset: o, data: d, sel: s, level: l};
    return it;
  endfunction

  // Mostly timer programming, short ticks and interrupt traffic, with random content.
  function automatic ctic_item_t rand_item();
    ctic_item_t it;
    int pick;
    it = mk_item(2'($urandom), 19'($urandom), 2'($urandom), 2'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.command = ctic_pkg::CMD_TICK;
      if ($urandom_range(0, 9) != 0) it.elapsed = 19'($urandom_range(0, 3000));
    end else if (pick < 65) begin
      it.command = ctic_pkg::CMD_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        it.page = ctic_pkg::PAGE_TIMER;
        it.offset = ctic_pkg::TMR_PRELOAD;
        if ($urandom_range(0, 4) != 0) it.data[6:0] = 7'($urandom_range(0, 3));
      end else if (pick < 45) begin
        it.page = ctic_pkg::PAGE_TIMER;
        it.offset = ctic_pkg::TMR_CONTROL;
        it.data[0] = ($urandom_range(0, 4) != 0);
      end else if (pick < 60) begin
        it.page = ctic_pkg::PAGE_IRQ;
        it.offset = ctic_pkg::INT_MASK;
      end else if (pick < 75) begin
        it.page = ctic_pkg::PAGE_IRQ;
        it.offset = ctic_pkg::IRQ_STATUS;
      end
    end else if (pick < 85) begin
      it.command = ctic_pkg::CMD_READ;
    end else begin
      it.command = ctic_pkg::CMD_LINE;
    end
    return it;
  endfunction

  // Idle cycles before the next transaction; occasionally a run with no idling at all.
  function automatic int idle_draw(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (ctic_cmd_q.size() > 0) begin
        cur_item = ctic_cmd_q.pop_front();
        command <= cur_item.command;
        elapsed_cycles <= cur_item.elapsed;
        io_page <= cur_item.page;
        reg_offset <= cur_item.offset;
        write_data <= cur_item.data;
        line_select <= cur_item.sel;
        line_level <= cur_item.level;
        in_valid <= 1'b1;
        in_wait = idle_draw(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) out_wait = idle_draw(out_calm);
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      in_took = in_valid && !in_stall;
      out_took = out_valid && !out_stall;
      if (out_took) begin
        if (ctic_resp_q.size() == 0) begin
          $error("response with no transaction outstanding");
          mismatches++;
        end else begin
          want = ctic_resp_q.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("pending_lines", 8'(want.pending_lines), 8'(pending_lines));
          check_field("request_lines", 8'(want.request_lines), 8'(request_lines));
          check_field("timer_fired", 8'(want.timer_fired), 8'(timer_fired));
        end
      end
      if (in_took) ctic_resp_q.push_back(ctic_execute(cur_item));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = ctic_pkg::CMD_TICK;
    elapsed_cycles = '0;
    io_page = ctic_pkg::PAGE_TIMER;
    reg_offset = ctic_pkg::TMR_PRELOAD;
    write_data = '0;
    line_select = ctic_pkg::LINE_IRQ1;
    line_level = 1'b0;
    out_stall = 1'b0;
    tmr_count = '0;
    tmr_reload = '0;
    tmr_running = 1'b0;
    line_mask = '0;
    line_pending = '0;
    bus_latch = '0;

    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::IRQ_STATUS, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 19'h7FFFF, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    // Starting with a zero preload gives a zero count that fires on every tick.
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_CONTROL, 8'h01, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_LINE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, ctic_pkg::LINE_IRQ1, 1));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::INT_MASK, 8'hFF, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::INT_MASK, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::IRQ_STATUS, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::IRQ_STATUS, 8'h00, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_LINE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, LINE_IRQ2, 1));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_IRQ,
                                 ctic_pkg::INT_MASK, 8'h00, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 8'hFF, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_CONTROL, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 19'd131071, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::IRQ_STATUS, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 19'd1, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 19'h7FFFF, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_CONTROL, 8'h00, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_TICK, 19'd5000, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_CONTROL, 8'h01, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, PAGE_OTHER, OFS_LATCH1, 8'hA5, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, PAGE_SPARE,
                                 ctic_pkg::IRQ_STATUS, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, PAGE_SPARE, OFS_LATCH0, 8'h5A, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_READ, 0, ctic_pkg::PAGE_IRQ,
                                 OFS_LATCH0, 0, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_WRITE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::INT_MASK, 8'h3C, 0, 0));
    ctic_cmd_q.push_back(mk_item(ctic_pkg::CMD_LINE, 0, ctic_pkg::PAGE_TIMER,
                                 ctic_pkg::TMR_PRELOAD, 0, ctic_pkg::LINE_IRQ1, 0));
    for (int n = 0; n < RANDOM_ITEMS; n++) ctic_cmd_q.push_back(rand_item());

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (ctic_cmd_q.size() != 0 || in_valid || ctic_resp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
